// ===== src/hct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_pkg
// Shared types, codes and helpers for the hours:minutes:seconds countdown timer.
// ----------------------------------------------------------------------------
package hct_pkg;

    localparam int HoursW   = 7;
    localparam int MinSecW  = 6;
    localparam int StepW    = 6;
    localparam int CfgAddrW = 1;
    localparam int CfgDataW = 7;
    localparam int InDataW  = 8;
    localparam int InUserW  = 2;
    localparam int OutDataW = 24;

    localparam logic [HoursW-1:0]  HoursCap       = 7'd99;
    localparam logic [MinSecW-1:0] FieldMax       = 6'd59;
    localparam logic [HoursW-1:0]  HoursLimitRst  = 7'd24;
    localparam logic [StepW-1:0]   CoarseStepRst  = 6'd5;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_HOURS_LIMIT = 1'b0,
        CFG_COARSE_STEP = 1'b1
    } t_cfg_addr;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_PLAY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        SEL_HOURS   = 2'd0,
        SEL_MINUTES = 2'd1,
        SEL_SECONDS = 2'd2,
        SEL_NONE    = 2'd3
    } t_sel;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PAUSED  = 2'd1,
        MODE_RUNNING = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef struct packed {
        t_cmd       cmd;
        t_sel       field_select;
        logic       direction;
        logic       coarse;
    } t_item;

    typedef struct packed {
        logic [HoursW-1:0]  hours;
        logic [MinSecW-1:0] minutes;
        logic [MinSecW-1:0] seconds;
        logic [HoursW-1:0]  preset_hours;
        logic [MinSecW-1:0] preset_minutes;
        logic [MinSecW-1:0] preset_seconds;
        t_mode              mode;
    } t_timer_state;

    // up: min(v + step, limit), down: max(v - step, 0)
    function automatic logic [HoursW-1:0] adjust_value(
        input logic [HoursW-1:0] v,
        input logic [StepW-1:0]  step,
        input logic [HoursW-1:0] limit,
        input logic              down
    );
        logic [HoursW:0]   sum;
        logic [HoursW-1:0] step_x;
        logic [HoursW-1:0] res;
        step_x = {1'b0, step};
        sum    = {1'b0, v} + {1'b0, step_x};
        if (down) begin
            res = (v > step_x) ? (v - step_x) : '0;
        end else begin
            res = (sum > {1'b0, limit}) ? limit : sum[HoursW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/hct_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_step
// Next-state logic for one event: tick borrow, field adjust, stop, play/pause.
// ----------------------------------------------------------------------------
module hct_step (
    input  hct_pkg::t_timer_state        i_state,
    input  hct_pkg::t_item               i_item,
    input  logic [hct_pkg::HoursW-1:0]   i_hours_limit,
    input  logic [hct_pkg::StepW-1:0]    i_coarse_step,
    output hct_pkg::t_timer_state        o_state,
    output logic                         o_expired
);

    logic [hct_pkg::HoursW-1:0] hl_eff;
    logic [hct_pkg::StepW-1:0]  step;
    logic [hct_pkg::HoursW-1:0] adj_hours;
    logic [hct_pkg::HoursW-1:0] adj_minutes;
    logic [hct_pkg::HoursW-1:0] adj_seconds;

    assign hl_eff = (i_hours_limit > hct_pkg::HoursCap) ? hct_pkg::HoursCap : i_hours_limit;
    assign step   = i_item.coarse ? i_coarse_step : hct_pkg::StepW'(1);

    assign adj_hours   = hct_pkg::adjust_value(i_state.hours, step, hl_eff,
                                               i_item.direction);
    assign adj_minutes = hct_pkg::adjust_value({1'b0, i_state.minutes}, step,
                                               {1'b0, hct_pkg::FieldMax}, i_item.direction);
    assign adj_seconds = hct_pkg::adjust_value({1'b0, i_state.seconds}, step,
                                               {1'b0, hct_pkg::FieldMax}, i_item.direction);

    always_comb begin
        o_state   = i_state;
        o_expired = 1'b0;
        unique case (i_item.cmd)
            hct_pkg::CMD_TICK: begin
                if (i_state.mode == hct_pkg::MODE_RUNNING) begin
                    if (i_state.seconds != '0) begin
                        o_state.seconds = i_state.seconds - 1'b1;
                    end else if (i_state.minutes != '0) begin
                        o_state.minutes = i_state.minutes - 1'b1;
                        o_state.seconds = hct_pkg::FieldMax;
                    end else if (i_state.hours != '0) begin
                        o_state.hours   = i_state.hours - 1'b1;
                        o_state.minutes = hct_pkg::FieldMax;
                        o_state.seconds = hct_pkg::FieldMax;
                    end else begin
                        // count ran out: flag it, reload the preset and stop
                        o_expired       = 1'b1;
                        o_state.hours   = i_state.preset_hours;
                        o_state.minutes = i_state.preset_minutes;
                        o_state.seconds = i_state.preset_seconds;
                        o_state.mode    = hct_pkg::MODE_STOPPED;
                    end
                end
            end
            hct_pkg::CMD_ADJUST: begin
                if (i_state.mode == hct_pkg::MODE_STOPPED) begin
                    case (i_item.field_select)
                        hct_pkg::SEL_HOURS:   o_state.hours   = adj_hours;
                        hct_pkg::SEL_MINUTES: o_state.minutes = adj_minutes[hct_pkg::MinSecW-1:0];
                        hct_pkg::SEL_SECONDS: o_state.seconds = adj_seconds[hct_pkg::MinSecW-1:0];
                        default: ;
                    endcase
                end
            end
            hct_pkg::CMD_STOP: begin
                if (i_state.mode != hct_pkg::MODE_STOPPED) begin
                    o_state.hours   = i_state.preset_hours;
                    o_state.minutes = i_state.preset_minutes;
                    o_state.seconds = i_state.preset_seconds;
                    o_state.mode    = hct_pkg::MODE_STOPPED;
                end
            end
            hct_pkg::CMD_PLAY: begin
                if (i_state.mode == hct_pkg::MODE_RUNNING) begin
                    o_state.mode = hct_pkg::MODE_PAUSED;
                end else begin
                    if (i_state.mode == hct_pkg::MODE_STOPPED) begin
                        o_state.preset_hours   = i_state.hours;
                        o_state.preset_minutes = i_state.minutes;
                        o_state.preset_seconds = i_state.seconds;
                    end
                    o_state.mode = hct_pkg::MODE_RUNNING;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== src/hms_countdown_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_countdown_timer_core
// Countdown timer over a stream of events, one result transaction per event.
// ----------------------------------------------------------------------------
// path: the input register, then the result register, on the way to the master side
// throughput: one event per cycle while the master side does not stall, set by
// the single next-state pass between the input register and the result register
// reset: synchronous active low; count, preset zero, mode stopped,
// hours limit 24, coarse step 5, both sides empty
module hms_countdown_timer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hct_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  logic [hct_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // field_select[1:0], direction[2], coarse[3], zero [7:4]
    input  logic [hct_pkg::InDataW-1:0]    s_axis_tdata,
    // cmd[1:0]
    input  logic [hct_pkg::InUserW-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // hours_now[6:0], minutes_now[12:7], seconds_now[18:13], mode[20:19],
    // expired[21], zero [23:22]
    output logic [hct_pkg::OutDataW-1:0]   m_axis_tdata
);

    hct_pkg::t_timer_state        r_state;
    hct_pkg::t_timer_state        n_state;
    hct_pkg::t_item               r_item;
    logic                         r_in_valid;
    logic                         r_out_valid;
    logic [hct_pkg::OutDataW-1:0] r_out_data;
    logic [hct_pkg::HoursW-1:0]   r_hours_limit;
    logic [hct_pkg::StepW-1:0]    r_coarse_step;
    logic                         n_expired;
    logic                         advance;
    logic                         in_take;

    // item moves from the input register to the result register
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    hct_step u_step (
        .i_state       (r_state),
        .i_item        (r_item),
        .i_hours_limit (r_hours_limit),
        .i_coarse_step (r_coarse_step),
        .o_state       (n_state),
        .o_expired     (n_expired)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours_limit <= hct_pkg::HoursLimitRst;
            r_coarse_step <= hct_pkg::CoarseStepRst;
        end else if (i_cfg_we) begin
            unique case (hct_pkg::t_cfg_addr'(i_cfg_addr))
                hct_pkg::CFG_HOURS_LIMIT: r_hours_limit <= i_cfg_data[hct_pkg::HoursW-1:0];
                hct_pkg::CFG_COARSE_STEP: r_coarse_step <= i_cfg_data[hct_pkg::StepW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: hct_pkg::MODE_STOPPED, default: '0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.cmd          <= hct_pkg::t_cmd'(s_axis_tuser);
            r_item.field_select <= hct_pkg::t_sel'(s_axis_tdata[1:0]);
            r_item.direction    <= s_axis_tdata[2];
            r_item.coarse       <= s_axis_tdata[3];
        end
        if (advance) begin
            r_out_data <= {2'b00, n_expired, n_state.mode, n_state.seconds,
                           n_state.minutes, n_state.hours};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the hours:minutes:seconds countdown timer core. Events
// (ticks, adjustments, stop and play/pause presses) are sent through the input
// stream under random gaps and output back-pressure. Each result transaction is
// checked field by field against an in-bench timer model that tracks count,
// preset, mode and both configuration registers.
// ----------------------------------------------------------------------------
module tb_top;
    import hct_pkg::*;

    localparam int WatchdogLimit = 1000;
    localparam int MaxPrinted    = 100;

    typedef struct packed {
        logic [HoursW-1:0]  hours;
        logic [MinSecW-1:0] minutes;
        logic [MinSecW-1:0] seconds;
        t_mode              mode;
        logic               expired;
    } t_reading;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgAddrW-1:0] i_cfg_addr;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic [InUserW-1:0]  s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;

    // timer model state
    logic [HoursW-1:0]  hours_limit_reg = HoursLimitRst;
    logic [StepW-1:0]   coarse_reg      = CoarseStepRst;
    logic [HoursW-1:0]  cnt_h = '0, pre_h = '0;
    logic [MinSecW-1:0] cnt_m = '0, cnt_s = '0, pre_m = '0, pre_s = '0;
    t_mode              cur_mode = MODE_STOPPED;

    t_reading expected_readings[$];
    int       mismatches  = 0;
    int       items_sent  = 0;
    bit       tx_idle     = 1'b1;
    bit       rx_idle     = 1'b1;
    int       rx_hold_req = 0;

    hms_countdown_timer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MaxPrinted) begin
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic int unsigned step_field(input int unsigned v, input int unsigned incr,
                                               input int unsigned lim, input logic dn);
        if (dn) begin
            return (v > incr) ? v - incr : 0;
        end
        return (v + incr > lim) ? lim : v + incr;
    endfunction

    task automatic reload_preset();
        cnt_h    = pre_h;
        cnt_m    = pre_m;
        cnt_s    = pre_s;
        cur_mode = MODE_STOPPED;
    endtask

    // applies one accepted event to the model and queues the reading it produces
    task automatic advance_timer(input t_item it);
        t_reading    r;
        int unsigned incr;
        int unsigned lim;
        incr      = it.coarse ? int'(coarse_reg) : 1;
        lim       = (hours_limit_reg > HoursCap) ? int'(HoursCap) : int'(hours_limit_reg);
        r.expired = 1'b0;
        case (it.cmd)
            CMD_TICK: begin
                if (cur_mode == MODE_RUNNING) begin
                    if (cnt_s != 0) begin
                        cnt_s = cnt_s - 1'b1;
                    end else if (cnt_m != 0) begin
                        cnt_m = cnt_m - 1'b1;
                        cnt_s = FieldMax;
                    end else if (cnt_h != 0) begin
                        cnt_h = cnt_h - 1'b1;
                        cnt_m = FieldMax;
                        cnt_s = FieldMax;
                    end else begin
                        r.expired = 1'b1;
                        reload_preset();
                    end
                end
            end
            CMD_ADJUST: begin
                if (cur_mode == MODE_STOPPED) begin
                    case (it.field_select)
                        SEL_HOURS: begin
                            cnt_h = HoursW'(step_field(cnt_h, incr, lim, it.direction));
                        end
                        SEL_MINUTES: begin
                            cnt_m = MinSecW'(step_field(cnt_m, incr, FieldMax, it.direction));
                        end
                        SEL_SECONDS: begin
                            cnt_s = MinSecW'(step_field(cnt_s, incr, FieldMax, it.direction));
                        end
                        default: ;
                    endcase
                end
            end
            CMD_STOP: begin
                if (cur_mode != MODE_STOPPED) begin
                    reload_preset();
                end
            end
            CMD_PLAY: begin
                if (cur_mode == MODE_RUNNING) begin
                    cur_mode = MODE_PAUSED;
                end else begin
                    if (cur_mode == MODE_STOPPED) begin
                        pre_h = cnt_h;
                        pre_m = cnt_m;
                        pre_s = cnt_s;
                    end
                    cur_mode = MODE_RUNNING;
                end
            end
            default: ;
        endcase
        r.hours   = cnt_h;
        r.minutes = cnt_m;
        r.seconds = cnt_s;
        r.mode    = cur_mode;
        expected_readings.push_back(r);
    endtask

    // valid is left high after a transaction so back-to-back events need no gap
    task automatic send_event(input t_cmd c, input t_sel s, input logic dn, input logic cs);
        t_item it;
        int    gap;
        it.cmd          = c;
        it.field_select = s;
        it.direction    = dn;
        it.coarse       = cs;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, cs, dn, s};
        s_axis_tuser  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_timer(it);
        items_sent++;
    endtask

    task automatic send_any_fields(input t_cmd c);
        send_event(c, t_sel'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr a, input logic [CfgDataW-1:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_data <= v;
        @(posedge i_clk);
        if (a == CFG_HOURS_LIMIT) begin
            hours_limit_reg = v;
        end else begin
            coarse_reg = v[StepW-1:0];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_idle_commands();
        send_event(CMD_TICK, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_STOP, SEL_SECONDS, 1'b1, 1'b1);
    endtask

    task automatic test_adjust_limits();
        write_reg(CFG_HOURS_LIMIT, 7'd127);
        write_reg(CFG_COARSE_STEP, 7'd63);
        send_event(CMD_ADJUST, SEL_HOURS, 1'b0, 1'b1);
        send_event(CMD_ADJUST, SEL_HOURS, 1'b0, 1'b1);   // limit saturates at 99
        send_event(CMD_ADJUST, SEL_MINUTES, 1'b0, 1'b1);
        send_event(CMD_ADJUST, SEL_MINUTES, 1'b1, 1'b1);
        send_event(CMD_ADJUST, SEL_SECONDS, 1'b0, 1'b1);
        send_event(CMD_ADJUST, SEL_NONE, 1'b0, 1'b1);
        // hours above the new limit get pulled down on increase
        write_reg(CFG_HOURS_LIMIT, 7'd10);
        send_event(CMD_ADJUST, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_ADJUST, SEL_HOURS, 1'b1, 1'b0);
        write_reg(CFG_HOURS_LIMIT, 7'd0);
        write_reg(CFG_COARSE_STEP, 7'd0);
        send_event(CMD_ADJUST, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_ADJUST, SEL_SECONDS, 1'b1, 1'b1);
        send_event(CMD_ADJUST, SEL_SECONDS, 1'b0, 1'b1);
    endtask

    task automatic test_countdown();
        write_reg(CFG_HOURS_LIMIT, 7'd24);
        write_reg(CFG_COARSE_STEP, 7'd59);
        send_event(CMD_ADJUST, SEL_SECONDS, 1'b1, 1'b1);
        send_event(CMD_ADJUST, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_ADJUST, SEL_SECONDS, 1'b0, 1'b0);
        send_event(CMD_PLAY, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_TICK, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_TICK, SEL_HOURS, 1'b0, 1'b0);     // borrow from hours
        send_event(CMD_PLAY, SEL_HOURS, 1'b0, 1'b0);     // pause
        send_event(CMD_TICK, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_ADJUST, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_PLAY, SEL_HOURS, 1'b0, 1'b0);     // resume, preset kept
        send_event(CMD_STOP, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_ADJUST, SEL_HOURS, 1'b1, 1'b0);
        send_event(CMD_ADJUST, SEL_MINUTES, 1'b0, 1'b0);
        send_event(CMD_ADJUST, SEL_SECONDS, 1'b1, 1'b0);
        send_event(CMD_PLAY, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_TICK, SEL_HOURS, 1'b0, 1'b0);     // borrow from minutes
        send_event(CMD_STOP, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_ADJUST, SEL_MINUTES, 1'b1, 1'b0);
        send_event(CMD_PLAY, SEL_HOURS, 1'b0, 1'b0);
        send_event(CMD_TICK, SEL_HOURS, 1'b0, 1'b0);     // expires at zero
    endtask

    // output held off while input keeps coming, so the core fills and stalls
    task automatic test_backpressure();
        wait_idle();
        tx_idle     = 1'b0;
        rx_hold_req = 40;
        repeat (12) send_event(t_cmd'($urandom_range(0, 3)), t_sel'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_idle();
        tx_idle = 1'b1;
    endtask

    // well-formed session: set a short count, start it and tick down, with
    // occasional interruptions
    task automatic run_timer_session();
        int   n_tick;
        int   total;
        int   r;
        t_sel s;
        if (cur_mode != MODE_STOPPED) begin
            send_any_fields(CMD_STOP);
        end
        repeat ($urandom_range(1, 5)) begin
            r = $urandom_range(0, 19);
            s = (r < 10) ? SEL_SECONDS : (r < 14) ? SEL_MINUTES : (r < 17) ? SEL_HOURS : SEL_NONE;
            send_event(CMD_ADJUST, s, ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
        end
        send_any_fields(CMD_PLAY);
        total  = int'(cnt_h) * 3600 + int'(cnt_m) * 60 + int'(cnt_s);
        n_tick = (total < 60) ? total + $urandom_range(1, 3) : $urandom_range(5, 40);
        repeat (n_tick) begin
            if ($urandom_range(0, 15) == 0) begin
                send_any_fields(t_cmd'($urandom_range(1, 3)));
            end else begin
                send_any_fields(CMD_TICK);
            end
        end
    endtask

    task automatic test_random_traffic();
        int target;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_HOURS_LIMIT, 7'd24);
                    write_reg(CFG_COARSE_STEP, 7'd5);
                end
                1: begin
                    write_reg(CFG_HOURS_LIMIT, 7'd1);
                    write_reg(CFG_COARSE_STEP, 7'd1);
                end
                2: begin
                    write_reg(CFG_HOURS_LIMIT, 7'd99);
                    write_reg(CFG_COARSE_STEP, 7'd59);
                end
                3: begin
                    write_reg(CFG_HOURS_LIMIT, 7'd127);
                    write_reg(CFG_COARSE_STEP, 7'd63);
                end
                4: begin
                    write_reg(CFG_HOURS_LIMIT, 7'd0);
                    write_reg(CFG_COARSE_STEP, 7'd0);
                end
                default: begin
                    write_reg(CFG_HOURS_LIMIT, CfgDataW'($urandom_range(0, 127)));
                    write_reg(CFG_COARSE_STEP, CfgDataW'($urandom_range(0, 63)));
                end
            endcase
            tx_idle = ph[0];
            rx_idle = ph[1];
            target  = items_sent + 250;
            while (items_sent < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 5)) begin
                        send_any_fields(t_cmd'($urandom_range(0, 3)));
                    end
                end else begin
                    run_timer_session();
                end
            end
        end
    endtask

    // result side: random stalls per transaction, plus long hold-offs on request
    initial begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = rx_idle ? $urandom_range(0, 7) : 0;
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid && rx_hold_req == 0);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_reading got;
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hours   = m_axis_tdata[6:0];
            got.minutes = m_axis_tdata[12:7];
            got.seconds = m_axis_tdata[18:13];
            got.mode    = t_mode'(m_axis_tdata[20:19]);
            got.expired = m_axis_tdata[21];
            if (expected_readings.size() == 0) begin
                report_mismatch("result with nothing pending, hours", got.hours, -1);
            end else begin
                want = expected_readings.pop_front();
                if (got.hours != want.hours) report_mismatch("hours", got.hours, want.hours);
                if (got.minutes != want.minutes) begin
                    report_mismatch("minutes", got.minutes, want.minutes);
                end
                if (got.seconds != want.seconds) begin
                    report_mismatch("seconds", got.seconds, want.seconds);
                end
                if (got.mode != want.mode) report_mismatch("mode", got.mode, want.mode);
                if (got.expired != want.expired) begin
                    report_mismatch("expired", got.expired, want.expired);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL hms_countdown_timer_core");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_HOURS_LIMIT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_TICK;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_commands();
        test_adjust_limits();
        test_countdown();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0) begin
            $display("PASS hms_countdown_timer_core");
        end else begin
            $display("FAIL hms_countdown_timer_core");
        end
        $finish;
    end

endmodule
